/* hw/rtl/rcfp_pkg.sv */
// Package for the row cache with FIFO replacement and pinning.
// Holds shared sizes, mode and status codes. No dependencies.
package rcfp_pkg;
    localparam int RES_CAP_DEFAULT = 64;
    localparam int PIN_CAP_DEFAULT = 64;
    localparam int ROW_W = 31;
    localparam int PAY_W = 32;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_LAST   = 2'd2,
        MODE_OTHER  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    localparam logic CFG_MAX_SIZE  = 1'b0;
    localparam logic CFG_PIN_COUNT = 1'b1;
endpackage

/* hw/rtl/row_cache_fifo_with_pinning.sv */
// A lookup compares one pinned entry, then one resident entry, per cycle through
// registered reads; a miss returns once both stores have been scanned. An insert then
// adds a decision state, an eviction when the resident store is at its limit, and a
// free-slot search. A set-last-row item reads the resident entries in age order; one in
// the end window takes a pinned free-slot search and, if moved, has its age slot closed.
// One item at a time; reset is asynchronous and clears valid bits, queue state and registers.
// Top level of the row cache; uses rcfp_pkg.
// Entries live in per-entry valid flops and arrays scanned by a comparator per store.
module row_cache_fifo_with_pinning #(
    parameter int RES_CAP = rcfp_pkg::RES_CAP_DEFAULT,
    parameter int PIN_CAP = rcfp_pkg::PIN_CAP_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] mode, [32:2] row, [64:33] payload, zero fill to 72 bits
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [33:2] hit_payload, [34] was_pinned, [35] evicted,
    // [66:36] evicted_row, zero fill to 72 bits
    output logic [71:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import rcfp_pkg::*;

    localparam int RW = $clog2(RES_CAP);
    localparam int PW = $clog2(PIN_CAP);
    localparam int CW = $clog2(RES_CAP + 1);
    localparam int SW = (RW > PW ? RW : PW) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCANP, S_SCANR, S_INS, S_EVICT, S_EVROW, S_FREER, S_WALK, S_WALKA,
        S_WALKR, S_FREEP, S_SHIFT, S_SHIFTW, S_OUT
    } state_t;

    state_t state_reg;
    logic [RES_CAP-1:0] rv_reg;
    logic [PIN_CAP-1:0] pv_reg;
    logic [ROW_W-1:0] rrow_mem [RES_CAP];
    logic [PAY_W-1:0] rpay_mem [RES_CAP];
    logic [ROW_W-1:0] prow_mem [PIN_CAP];
    logic [PAY_W-1:0] ppay_mem [PIN_CAP];
    logic [RW-1:0] age_mem [RES_CAP];
    logic [RW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic          known_reg;
    logic [ROW_W-1:0] last_reg;
    logic [6:0] max_size_reg;
    logic [7:0] pin_count_reg;

    logic [1:0] mode_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PAY_W-1:0] pay_reg;
    logic [SW-1:0] idx_reg;
    logic [SW-1:0] cidx_reg;
    logic          chk_reg;
    logic [CW-1:0] k_reg;
    logic [RW-1:0] slot_reg;
    logic [ROW_W-1:0] srow_reg;
    logic [PAY_W-1:0] spay_reg;

    logic [ROW_W-1:0] prow_rd_reg;
    logic [PAY_W-1:0] ppay_rd_reg;
    logic [ROW_W-1:0] rrow_rd_reg;
    logic [PAY_W-1:0] rpay_rd_reg;
    logic [RW-1:0]    age_rd_reg;

    logic [1:0] st_reg;
    logic [PAY_W-1:0] hit_reg;
    logic wp_reg, ev_reg;
    logic [ROW_W-1:0] evrow_reg;

    logic [CW-1:0] limit;
    logic pin_new, pin_walk;
    logic p_re, r_re, a_we, take_p, take_r;
    logic [RW-1:0] r_raddr, a_raddr, a_waddr, a_wdata;

    function automatic logic in_end(input logic [ROW_W-1:0] r, input logic kn,
                                    input logic [ROW_W-1:0] last, input logic [7:0] pc);
        // r > last - pc  <=>  r + pc > last
        return kn && ({1'b0, r} + {{(ROW_W-7){1'b0}}, pc} > {1'b0, last});
    endfunction

    // Age queue position: head plus offset, wrapped once at the capacity.
    function automatic logic [RW-1:0] qpos(input logic [RW-1:0] h, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW+1-RW){1'b0}}, h} + {1'b0, off};
        if (s >= (CW+1)'(RES_CAP))
            s = s - (CW+1)'(RES_CAP);
        return s[RW-1:0];
    endfunction

    always_comb
    begin
        if (max_size_reg == 7'd0 || {25'd0, max_size_reg} > RES_CAP)
            limit = CW'(RES_CAP);
        else
            limit = CW'(max_size_reg);
        pin_new = (pin_count_reg != 8'd0) &&
                  ({1'b0, row_reg} < {24'd0, pin_count_reg} ||
                   in_end(row_reg, known_reg, last_reg, pin_count_reg));
        pin_walk = in_end(srow_reg, known_reg, last_reg, pin_count_reg);

        p_re   = (state_reg == S_SCANP) && (idx_reg < SW'(PIN_CAP));
        take_p = (state_reg == S_FREEP) && (mode_reg != MODE_LAST || pin_walk) &&
                 !pv_reg[idx_reg[PW-1:0]];
        take_r = (state_reg == S_FREER) && !rv_reg[idx_reg[RW-1:0]];

        if (state_reg == S_SCANR)
        begin
            r_re    = (idx_reg < SW'(RES_CAP));
            r_raddr = idx_reg[RW-1:0];
        end
        else if (state_reg == S_EVICT || state_reg == S_WALKA)
        begin
            r_re    = 1'b1;
            r_raddr = age_rd_reg;
        end
        else
        begin
            r_re    = 1'b0;
            r_raddr = idx_reg[RW-1:0];
        end

        if (state_reg == S_WALK)
            a_raddr = qpos(head_reg, k_reg);
        else if (state_reg == S_SHIFT)
            a_raddr = qpos(head_reg, CW'(idx_reg + 1'b1));
        else
            a_raddr = head_reg;

        if (take_r)
        begin
            a_we    = 1'b1;
            a_waddr = qpos(head_reg, count_reg);
            a_wdata = idx_reg[RW-1:0];
        end
        else if (state_reg == S_SHIFTW)
        begin
            a_we    = 1'b1;
            a_waddr = qpos(head_reg, CW'(idx_reg));
            a_wdata = age_rd_reg;
        end
        else
        begin
            a_we    = 1'b0;
            a_waddr = head_reg;
            a_wdata = age_rd_reg;
        end
    end

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {5'd0, evrow_reg, ev_reg, wp_reg, hit_reg, st_reg};

    always_ff @(posedge clk)
    begin
        if (take_p)
        begin
            prow_mem[idx_reg[PW-1:0]] <= srow_reg;
            ppay_mem[idx_reg[PW-1:0]] <= spay_reg;
        end
        if (p_re)
        begin
            prow_rd_reg <= prow_mem[idx_reg[PW-1:0]];
            ppay_rd_reg <= ppay_mem[idx_reg[PW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_r)
        begin
            rrow_mem[idx_reg[RW-1:0]] <= row_reg;
            rpay_mem[idx_reg[RW-1:0]] <= pay_reg;
        end
        if (r_re)
        begin
            rrow_rd_reg <= rrow_mem[r_raddr];
            rpay_rd_reg <= rpay_mem[r_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
            age_mem[a_waddr] <= a_wdata;
        age_rd_reg <= age_mem[a_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rv_reg        <= '0;
            pv_reg        <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            known_reg     <= 1'b0;
            chk_reg       <= 1'b0;
            max_size_reg  <= '0;
            pin_count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == CFG_MAX_SIZE) max_size_reg <= cfg_data[6:0];
                        else pin_count_reg <= cfg_data;
                    end
                    else if (s_tvalid)
                    begin
                        mode_reg  <= s_tdata[1:0];
                        row_reg   <= s_tdata[32:2];
                        pay_reg   <= s_tdata[64:33];
                        st_reg    <= ST_OK;
                        hit_reg   <= '0;
                        wp_reg    <= 1'b0;
                        ev_reg    <= 1'b0;
                        evrow_reg <= '0;
                        idx_reg   <= '0;
                        chk_reg   <= 1'b0;
                        k_reg     <= '0;
                        if (s_tdata[1:0] == MODE_LAST)
                        begin
                            known_reg <= 1'b1;
                            last_reg  <= s_tdata[32:2];
                            state_reg <= (pin_count_reg != 8'd0) ? S_WALK : S_OUT;
                        end
                        else
                            state_reg <= S_SCANP;
                    end
                end
                S_SCANP:
                begin
                    // Reads are issued at idx_reg; the compare sees the entry at cidx_reg.
                    if (chk_reg && pv_reg[cidx_reg[PW-1:0]] && prow_rd_reg == row_reg)
                    begin
                        if (mode_reg == MODE_INSERT) st_reg <= ST_PRESENT;
                        else
                        begin
                            hit_reg <= ppay_rd_reg;
                            wp_reg  <= 1'b1;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (chk_reg && cidx_reg == SW'(PIN_CAP - 1))
                    begin
                        idx_reg   <= '0;
                        chk_reg   <= 1'b0;
                        state_reg <= S_SCANR;
                    end
                    else
                    begin
                        chk_reg  <= 1'b1;
                        cidx_reg <= idx_reg;
                        idx_reg  <= idx_reg + 1'b1;
                    end
                end
                S_SCANR:
                begin
                    if (chk_reg && rv_reg[cidx_reg[RW-1:0]] && rrow_rd_reg == row_reg)
                    begin
                        if (mode_reg == MODE_INSERT) st_reg <= ST_PRESENT;
                        else hit_reg <= rpay_rd_reg;
                        state_reg <= S_OUT;
                    end
                    else if (chk_reg && cidx_reg == SW'(RES_CAP - 1))
                    begin
                        idx_reg <= '0;
                        chk_reg <= 1'b0;
                        if (mode_reg == MODE_INSERT) state_reg <= S_INS;
                        else
                        begin
                            st_reg    <= ST_ABSENT;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        chk_reg  <= 1'b1;
                        cidx_reg <= idx_reg;
                        idx_reg  <= idx_reg + 1'b1;
                    end
                end
                S_INS:
                begin
                    if (pin_new)
                    begin
                        srow_reg  <= row_reg;
                        spay_reg  <= pay_reg;
                        state_reg <= S_FREEP;
                    end
                    else if (count_reg != '0 && count_reg >= limit)
                        state_reg <= S_EVICT;
                    else
                        state_reg <= S_FREER;
                end
                S_EVICT:
                begin
                    // The age queue head is valid now; its row is read next.
                    slot_reg  <= age_rd_reg;
                    state_reg <= S_EVROW;
                end
                S_EVROW:
                begin
                    ev_reg    <= 1'b1;
                    evrow_reg <= rrow_rd_reg;
                    rv_reg[slot_reg] <= 1'b0;
                    head_reg  <= qpos(head_reg, CW'(1));
                    count_reg <= count_reg - 1'b1;
                    state_reg <= S_FREER;
                end
                S_FREER:
                begin
                    // The lowest free slot is taken; one exists because count stays below capacity.
                    if (take_r)
                    begin
                        rv_reg[idx_reg[RW-1:0]] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (idx_reg == SW'(RES_CAP - 1))
                        state_reg <= S_OUT;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_WALK:
                begin
                    if (k_reg >= count_reg) state_reg <= S_OUT;
                    else state_reg <= S_WALKA;
                end
                S_WALKA:
                begin
                    slot_reg  <= age_rd_reg;
                    state_reg <= S_WALKR;
                end
                S_WALKR:
                begin
                    srow_reg <= rrow_rd_reg;
                    spay_reg <= rpay_rd_reg;
                    idx_reg  <= '0;
                    state_reg <= S_FREEP;
                end
                S_FREEP:
                begin
                    if (mode_reg == MODE_LAST && !pin_walk)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_WALK;
                    end
                    else if (take_p)
                    begin
                        pv_reg[idx_reg[PW-1:0]] <= 1'b1;
                        if (mode_reg == MODE_INSERT)
                        begin
                            wp_reg    <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            rv_reg[slot_reg] <= 1'b0;
                            if (k_reg == '0)
                            begin
                                head_reg  <= qpos(head_reg, CW'(1));
                                count_reg <= count_reg - 1'b1;
                                state_reg <= S_WALK;
                            end
                            else
                            begin
                                idx_reg   <= SW'(k_reg);
                                state_reg <= S_SHIFT;
                            end
                        end
                    end
                    else if (idx_reg == SW'(PIN_CAP - 1))
                    begin
                        if (mode_reg == MODE_INSERT)
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_WALK;
                        end
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_SHIFT:
                begin
                    // Close the gap in the age queue: read the next position, then write.
                    if (CW'(idx_reg) + 1'b1 < count_reg)
                        state_reg <= S_SHIFTW;
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_WALK;
                    end
                end
                S_SHIFTW:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SHIFT;
                end
                S_OUT:
                begin
                    if (m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RES_CAP)) else $error("resident count over capacity");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("accepting while result pending");
    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ev_reg) |-> (mode_reg == MODE_INSERT && st_reg == ST_OK))
        else $error("eviction outside successful insert");
`endif
endmodule

/* bench/tb_row_cache_fifo_with_pinning.sv */
// Self-checking testbench for row_cache_fifo_with_pinning.
// Predicts each lookup, insert and end-row update in a scoreboard class and
// checks every output transfer; depends on rcfp_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_row_cache_fifo_with_pinning;
    import rcfp_pkg::*;

    localparam int RCAP = 64;
    localparam int PCAP = 64;

    typedef struct packed {
        logic [30:0] evicted_row;
        logic        evicted;
        logic        was_pinned;
        logic [31:0] hit_payload;
        logic [1:0]  status;
    } result_t;

    class row_cache_scoreboard;
        bit          rv[RCAP];
        bit [30:0]   rrow[RCAP];
        bit [31:0]   rpay[RCAP];
        bit          pv[PCAP];
        bit [30:0]   prow[PCAP];
        bit [31:0]   ppay[PCAP];
        int          age[RCAP];
        int          head;
        int          count;
        longint      last_row;
        int          max_size;
        int          pin_count;
        result_t     pending[$];
        int          errors;

        function new();
            for (int i = 0; i < RCAP; i++) rv[i] = 0;
            for (int i = 0; i < PCAP; i++) pv[i] = 0;
            head = 0; count = 0; last_row = -1;
            max_size = 0; pin_count = 0; errors = 0;
        endfunction

        function int qpos(int k);
            return (head + k) % RCAP;
        endfunction

        function void age_drop(int k);
            if (k == 0) head = (head + 1) % RCAP;
            else for (int i = k; i + 1 < count; i++) age[qpos(i)] = age[qpos(i + 1)];
            count--;
        endfunction

        function bit at_end(bit [30:0] r);
            return last_row >= 0 && longint'(r) > last_row - pin_count;
        endfunction

        function int free_pin();
            for (int i = 0; i < PCAP; i++) if (!pv[i]) return i;
            return -1;
        endfunction

        function void set_reg(bit idx, int val);
            if (idx == CFG_MAX_SIZE) max_size = val; else pin_count = val;
        endfunction

        function void note_item(mode_t m, bit [30:0] r, bit [31:0] pay);
            result_t e;
            int p, fr, fp, lim, s, k;
            e = '0;
            fp = -1; fr = -1;
            for (int i = 0; i < PCAP; i++) if (pv[i] && prow[i] == r && fp < 0) fp = i;
            for (int i = 0; i < RCAP; i++) if (rv[i] && rrow[i] == r && fr < 0) fr = i;
            if (m == MODE_INSERT) begin
                if (fp >= 0 || fr >= 0) e.status = ST_PRESENT;
                else if (pin_count > 0 && (r < pin_count || at_end(r))) begin
                    p = free_pin();
                    if (p < 0) e.status = ST_FULL;
                    else begin
                        pv[p] = 1; prow[p] = r; ppay[p] = pay; e.was_pinned = 1;
                    end
                end else begin
                    lim = (max_size == 0 || max_size > RCAP) ? RCAP : max_size;
                    if (count > 0 && count >= lim) begin
                        s = age[qpos(0)];
                        e.evicted = 1; e.evicted_row = rrow[s];
                        rv[s] = 0;
                        age_drop(0);
                    end
                    for (int i = 0; i < RCAP; i++)
                        if (!rv[i]) begin
                            rv[i] = 1; rrow[i] = r; rpay[i] = pay;
                            age[qpos(count)] = i; count++;
                            break;
                        end
                end
            end else if (m == MODE_LAST) begin
                last_row = r;
                if (pin_count > 0) begin
                    k = 0;
                    while (k < count) begin
                        s = age[qpos(k)];
                        p = at_end(rrow[s]) ? free_pin() : -1;
                        if (p >= 0) begin
                            pv[p] = 1; prow[p] = rrow[s]; ppay[p] = rpay[s];
                            rv[s] = 0; age_drop(k);
                        end else k++;
                    end
                end
            end else begin
                if (fp >= 0) begin
                    e.hit_payload = ppay[fp]; e.was_pinned = 1;
                end else if (fr >= 0) e.hit_payload = rpay[fr];
                else e.status = ST_ABSENT;
            end
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (got !== e) begin
                $display("%0t: mismatch expected st=%0d pay=%h pin=%0d ev=%0d evrow=%h",
                         $time, e.status, e.hit_payload, e.was_pinned, e.evicted,
                         e.evicted_row);
                $display("%0t:          actual   st=%0d pay=%h pin=%0d ev=%0d evrow=%h",
                         $time, got.status, got.hit_payload, got.was_pinned,
                         got.evicted, got.evicted_row);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_index = 0;
    logic [7:0]  cfg_data = '0;

    row_cache_scoreboard sb;
    bit  quiet_mode = 0;
    bit  hold_sink = 0;

    row_cache_fifo_with_pinning uut (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    task automatic write_reg(bit idx, int val);
        @(negedge clk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val[7:0];
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic send_item(mode_t m, bit [30:0] r, bit [31:0] pay);
        @(negedge clk);
        while (!quiet_mode && $urandom_range(99) < 9) @(negedge clk);
        s_tvalid <= 1;
        s_tdata <= {7'd0, pay, r, m};
        do @(posedge clk); while (!s_tready);
        sb.note_item(m, r, pay);
        @(negedge clk);
        s_tvalid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Random rows mostly from a small pool so hits, duplicates and pins happen.
    function automatic bit [30:0] pick_row();
        int c;
        c = $urandom_range(99);
        if (c < 75) return 31'($urandom_range(120));
        if (c < 85) return 31'h7fffffff - 31'($urandom_range(3));
        return 31'($urandom() >> 1);
    endfunction

    task automatic random_phase(int n);
        int c;
        mode_t m;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(99);
            m = c < 40 ? MODE_LOOKUP : c < 85 ? MODE_INSERT : c < 95 ? MODE_LAST : MODE_OTHER;
            if (m == MODE_LAST && $urandom_range(1))
                send_item(m, 31'($urandom_range(200)), $urandom());
            else send_item(m, pick_row(), $urandom());
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_sink) m_tready <= 0;
        else if (quiet_mode) m_tready <= 1;
        else m_tready <= ($urandom_range(99) >= 9);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(result_t'(m_tdata[66:0]));
    end

    initial
    begin
        #400000000;
        $display("tb_row_cache_fifo_with_pinning: errors");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: defaults, then small limit with pinning.
        send_item(MODE_LOOKUP, 31'd5, 32'd0);
        send_item(MODE_INSERT, 31'd0, 32'hffffffff);
        send_item(MODE_INSERT, 31'h7fffffff, 32'h0);
        send_item(MODE_INSERT, 31'd0, 32'h1);
        send_item(MODE_LOOKUP, 31'd0, 32'h0);
        send_item(MODE_OTHER, 31'h7fffffff, 32'hffffffff);
        drain();
        write_reg(CFG_MAX_SIZE, 2);
        write_reg(CFG_PIN_COUNT, 3);
        send_item(MODE_INSERT, 31'd1, 32'haaaa5555);
        send_item(MODE_LOOKUP, 31'd1, 32'h0);
        send_item(MODE_INSERT, 31'd10, 32'h11);
        send_item(MODE_INSERT, 31'd11, 32'h22);
        send_item(MODE_INSERT, 31'd12, 32'h33);
        send_item(MODE_INSERT, 31'd11, 32'h44);
        send_item(MODE_LAST, 31'd13, 32'h0);
        send_item(MODE_LOOKUP, 31'd12, 32'h0);
        send_item(MODE_INSERT, 31'd13, 32'h55);
        send_item(MODE_LAST, 31'h7fffffff, 32'h0);
        drain();
        // Fill the pinned store with a wide start window until it refuses.
        write_reg(CFG_PIN_COUNT, 255);
        write_reg(CFG_MAX_SIZE, 64);
        for (int i = 100; i < 170; i++) send_item(MODE_INSERT, 31'(i), $urandom());
        drain();

        // Random phases over several settings, extremes included.
        for (int ph = 0; ph < 8; ph++) begin
            sb = sb;
            case (ph)
                0: begin write_reg(CFG_MAX_SIZE, 0);   write_reg(CFG_PIN_COUNT, 0); end
                1: begin write_reg(CFG_MAX_SIZE, 1);   write_reg(CFG_PIN_COUNT, 1); end
                2: begin write_reg(CFG_MAX_SIZE, 64);  write_reg(CFG_PIN_COUNT, 8); end
                3: begin write_reg(CFG_MAX_SIZE, 127); write_reg(CFG_PIN_COUNT, 128); end
                default: begin
                    write_reg(CFG_MAX_SIZE, $urandom_range(127));
                    write_reg(CFG_PIN_COUNT, $urandom_range(1) ? $urandom_range(20) : $urandom_range(255));
                end
            endcase
            if (ph == 2) begin
                quiet_mode = 1;
                hold_sink = 1;
                fork
                    begin
                        repeat (3000) @(posedge clk);
                        hold_sink = 0;
                    end
                    random_phase(40);
                join
                quiet_mode = 0;
            end
            random_phase(160);
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_row_cache_fifo_with_pinning: clean");
        else
            $display("tb_row_cache_fifo_with_pinning: errors");
        $finish;
    end
endmodule
